FILE: rtl/core/hcmv_pkg.sv
package hcmv_pkg;

    // Message layout
    localparam int HEADER_BYTES = 16;
    localparam int MIN_LENGTH   = HEADER_BYTES + 4;
    localparam int CNT_W        = $clog2(MIN_LENGTH + 1);
    localparam int OFS_W        = 4;
    // Width used to compare byte position against the property offset
    localparam int POS_CMP_W    = (CNT_W > OFS_W + 1) ? CNT_W : OFS_W + 1;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_PROP_VALUE_A = 2'd0;
    localparam cfg_index_t CFG_PROP_VALUE_B = 2'd1;
    localparam cfg_index_t CFG_PROP_OFFSET  = 2'd2;

    localparam logic [15:0]      PROP_VALUE_A_RST = 16'h20C0;
    localparam logic [15:0]      PROP_VALUE_B_RST = 16'hA0C0;
    localparam logic [OFS_W-1:0] PROP_OFFSET_RST  = 4'd14;

    // Result status codes
    typedef logic [2:0] status_t;
    localparam status_t STATUS_TOO_SHORT  = 3'd0;
    localparam status_t STATUS_CRC_ERROR  = 3'd1;
    localparam status_t STATUS_PASS_A     = 3'd2;
    localparam status_t STATUS_PASS_B     = 3'd3;
    localparam status_t STATUS_PASS_OTHER = 3'd4;

    typedef struct packed {
        logic [15:0]      prop_value_a;
        logic [15:0]      prop_value_b;
        logic [OFS_W-1:0] prop_offset;
    } cfg_t;

    // One byte moving from the input register into the message state
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } step_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] crc;
    } result_t;

    // One byte of the reflected CRC-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/hcmv_msg_state.sv
module hcmv_msg_state
    import hcmv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  step_t   step,
    output result_t result
);

    logic [31:0]      crc_reg,   crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      tail_reg,  tail_next;
    logic [15:0]      prop_reg,  prop_next;

    logic [31:0]          crc_upd;
    logic [31:0]          crc_final;
    logic [CNT_W-1:0]     count_upd;
    logic [31:0]          tail_upd;
    logic [15:0]          prop_upd;
    logic                 in_header;
    logic [POS_CMP_W-1:0] pos_ext;
    logic [POS_CMP_W-1:0] ofs_ext;

    // Per-byte update of the running message state
    always_comb begin
        in_header = (count_reg < CNT_W'(HEADER_BYTES));
        pos_ext   = POS_CMP_W'(count_reg);
        ofs_ext   = POS_CMP_W'(cfg.prop_offset);
        crc_upd   = in_header ? crc_byte(crc_reg, step.data) : crc_reg;
        prop_upd  = prop_reg;
        if (in_header && (pos_ext == ofs_ext)) begin
            prop_upd[7:0] = step.data;
        end else if (in_header && (pos_ext == ofs_ext + POS_CMP_W'(1))) begin
            prop_upd[15:8] = step.data;
        end
        tail_upd  = {step.data, tail_reg[31:8]};
        count_upd = (count_reg < CNT_W'(MIN_LENGTH)) ? count_reg + CNT_W'(1) : count_reg;
        crc_final = crc_upd ^ CRC_INIT;
    end

    // Classify the message on its last byte
    always_comb begin
        result.valid = step.valid && step.last;
        result.crc   = crc_final;
        if (count_upd < CNT_W'(MIN_LENGTH)) begin
            result.status = STATUS_TOO_SHORT;
            result.crc    = '0;
        end else if (crc_final != tail_upd) begin
            result.status = STATUS_CRC_ERROR;
        end else if (prop_upd == cfg.prop_value_a) begin
            result.status = STATUS_PASS_A;
        end else if (prop_upd == cfg.prop_value_b) begin
            result.status = STATUS_PASS_B;
        end else begin
            result.status = STATUS_PASS_OTHER;
        end
    end

    // Next state: the last byte returns everything to the idle values
    always_comb begin
        crc_next   = crc_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        prop_next  = prop_reg;
        if (step.valid) begin
            if (step.last) begin
                crc_next   = CRC_INIT;
                count_next = '0;
                tail_next  = '0;
                prop_next  = '0;
            end else begin
                crc_next   = crc_upd;
                count_next = count_upd;
                tail_next  = tail_upd;
                prop_next  = prop_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            tail_reg  <= '0;
            prop_reg  <= '0;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
            prop_reg  <= prop_next;
        end
    end

endmodule

FILE: rtl/core/hcmv_out_reg.sv
module hcmv_out_reg
    import hcmv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  result_t     result,
    output logic        slot_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata
);

    logic        valid_reg,  valid_next;
    status_t     status_reg, status_next;
    logic [31:0] crc_reg,    crc_next;

    // A new result may be loaded when the slot is empty or drains this cycle
    assign slot_free = !valid_reg || m_tready;

    always_comb begin
        valid_next  = valid_reg;
        status_next = status_reg;
        crc_next    = crc_reg;
        if (result.valid) begin
            valid_next  = 1'b1;
            status_next = result.status;
            crc_next    = result.crc;
        end else if (m_tready) begin
            valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        status_reg <= status_next;
        crc_reg    <= crc_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, crc_reg, status_reg};

endmodule

FILE: rtl/core/header_crc_message_validator_unit.sv
// Channel   Dir  Ports                                 Contents
// s_        in   s_tvalid s_tready s_tdata s_tlast     one message byte, last-byte flag
// m_        out  m_tvalid m_tready m_tdata             status and computed CRC
// cfg_      in   cfg_we cfg_index cfg_wdata            property values A/B, offset
//
// One byte per cycle while the output can take results: each byte is held in the input register,
// and the CRC byte update plus classification fit between it and the state/output
// registers. The last byte of a message waits in the input register only while
// the output register holds an untaken result. With a free output register,
// m_tvalid rises once the last byte has left the input register and its result is in the output register.
// Reset is synchronous, active low.
module header_crc_message_validator_unit
    import hcmv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [2:0] status, [34:3] computed_crc, [39:35] zero

    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t    cfg_reg, cfg_next;
    logic    in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic    in_last_reg;
    logic    slot_free;
    logic    advance;
    step_t   step;
    result_t result;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_PROP_VALUE_A: cfg_next.prop_value_a = cfg_wdata;
                CFG_PROP_VALUE_B: cfg_next.prop_value_b = cfg_wdata;
                CFG_PROP_OFFSET:  cfg_next.prop_offset  = cfg_wdata[OFS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_value_a <= PROP_VALUE_A_RST;
            cfg_reg.prop_value_b <= PROP_VALUE_B_RST;
            cfg_reg.prop_offset  <= PROP_OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register: a byte moves on unless it is a last byte facing a full output
    assign advance  = in_valid_reg && (!in_last_reg || slot_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign step = {advance, in_data_reg, in_last_reg};

    hcmv_msg_state u_msg_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .result  (result)
    );

    hcmv_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .result    (result),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A last byte never overwrites a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && m_tvalid && !m_tready) |-> !advance)
        else $error("last byte advanced into a full output register");

    // The last byte of a message produces a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> m_tvalid)
        else $error("result missing after last byte");

    // A too-short message always reports a zero CRC
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] == STATUS_TOO_SHORT)) |-> (m_tdata[34:3] == 32'd0))
        else $error("too-short result carries a nonzero CRC");

    // Bytes that are not last never create a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !(advance && in_last_reg)) |=> !m_tvalid)
        else $error("result appeared without a last byte");

endmodule
